[sv/esc_pkg.sv]
// Shared types and constants for the environmental sensor compensation block.
// No dependencies.
package esc_pkg;

  localparam int RawTW  = 20;
  localparam int RawPW  = 20;
  localparam int RawHW  = 16;
  localparam int TempW  = 32;
  localparam int PressW = 32;
  localparam int HumW   = 17;

  // Pressure divider: 64-bit dividend magnitude, divisor magnitude below 2^31.
  localparam int QuotW     = 64;
  localparam int DenW      = 32;
  localparam int DivStages = QuotW;

  localparam int AddrW = 6;
  localparam int DataW = 64;

  typedef enum logic [2:0] {
    RegCalTemp   = 3'd0,
    RegCalPressA = 3'd1,
    RegCalPressB = 3'd2,
    RegCalMixed  = 3'd3,
    RegCalHum    = 3'd4
  } esc_reg_e;

  // Results that ride along the divider.
  typedef struct packed {
    logic [TempW-1:0] temp;
    logic [HumW-1:0]  hum;
    logic             neg;
    logic             zero;
  } esc_side_t;

endpackage

[sv/esc_div_pipe.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on esc_pkg.
module esc_div_pipe import esc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [QuotW-1:0] num_i,
  input  logic [DenW-1:0]  den_i,
  input  esc_side_t        side_i,
  output logic             valid_o,
  output logic [QuotW-1:0] quot_o,
  output esc_side_t        side_o
);

  logic [DenW-1:0]  rem_q  [DivStages];
  logic [DenW-1:0]  den_q  [DivStages];
  logic [QuotW-1:0] num_q  [DivStages];
  esc_side_t        side_q [DivStages];
  logic [DivStages-1:0] vld_q;

  logic [DenW-1:0]  rem_p  [DivStages];
  logic [DenW-1:0]  den_p  [DivStages];
  logic [QuotW-1:0] num_p  [DivStages];
  esc_side_t        side_p [DivStages];
  logic [DenW:0]    trial_w [DivStages];
  logic [DivStages-1:0] ge_w;
  logic [DenW-1:0]  rem_d  [DivStages];
  logic [QuotW-1:0] num_d  [DivStages];

  always_comb begin
    for (int k = 0; k < DivStages; k++) begin
      if (k == 0) begin
        rem_p[k]  = '0;
        den_p[k]  = den_i;
        num_p[k]  = num_i;
        side_p[k] = side_i;
      end else begin
        rem_p[k]  = rem_q[k-1];
        den_p[k]  = den_q[k-1];
        num_p[k]  = num_q[k-1];
        side_p[k] = side_q[k-1];
      end
      trial_w[k] = {rem_p[k], num_p[k][QuotW-1]};
      ge_w[k]    = trial_w[k] >= {1'b0, den_p[k]};
      rem_d[k]   = ge_w[k] ? DenW'(trial_w[k] - {1'b0, den_p[k]}) : trial_w[k][DenW-1:0];
      num_d[k]   = {num_p[k][QuotW-2:0], ge_w[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DivStages; k++) begin
        rem_q[k]  <= rem_d[k];
        den_q[k]  <= den_p[k];
        num_q[k]  <= num_d[k];
        side_q[k] <= side_p[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivStages-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[DivStages-1];
  assign quot_o  = num_q[DivStages-1];
  assign side_o  = side_q[DivStages-1];

endmodule

[sv/env_sensor_compensation.sv]
// Top level: calibration registers and the compensation pipeline.
// Depends on esc_pkg and esc_div_pipe.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------------
//   input    | in_valid_i / in_stall_o   | raw_temperature_i, raw_pressure_i, raw_humidity_i
//   output   | out_valid_o / out_stall_i | temperature_o, pressure_o, humidity_o
//   config   | psel/penable/pwrite       | paddr, pwdata, prdata (8-byte registers)
//
// One item per cycle while the output is not stalled; 12 front stages, 64 divider stages
// (one quotient bit each), 5 back stages.
// Reset clears valid bits and calibration registers.
// A stalled output freezes the whole pipeline; in_stall_o follows it.
module env_sensor_compensation import esc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [RawTW-1:0]  raw_temperature_i,
  input  logic [RawPW-1:0]  raw_pressure_i,
  input  logic [RawHW-1:0]  raw_humidity_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TempW-1:0]  temperature_o,
  output logic [PressW-1:0] pressure_o,
  output logic [HumW-1:0]   humidity_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  localparam int FrontStages = 12;
  localparam int PostStages  = 5;

  // ---------------- configuration ----------------
  logic [47:0] cal_temp_q;
  logic [63:0] cal_press_a_q, cal_press_b_q;
  logic [47:0] cal_mixed_q;
  logic [39:0] cal_hum_q;
  esc_reg_e    reg_idx;

  assign reg_idx = esc_reg_e'(paddr[AddrW-1:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q    <= '0;
      cal_press_a_q <= '0;
      cal_press_b_q <= '0;
      cal_mixed_q   <= '0;
      cal_hum_q     <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegCalTemp:   cal_temp_q    <= pwdata[47:0];
        RegCalPressA: cal_press_a_q <= pwdata;
        RegCalPressB: cal_press_b_q <= pwdata;
        RegCalMixed:  cal_mixed_q   <= pwdata[47:0];
        RegCalHum:    cal_hum_q     <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegCalTemp:   prdata = {16'd0, cal_temp_q};
      RegCalPressA: prdata = cal_press_a_q;
      RegCalPressB: prdata = cal_press_b_q;
      RegCalMixed:  prdata = {16'd0, cal_mixed_q};
      RegCalHum:    prdata = {24'd0, cal_hum_q};
      default:      prdata = '0;
    endcase
  end

  logic signed [16:0] t1, p1, h1, h3;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2, h4, h5;
  logic signed [7:0]  h6;

  assign t1 = $signed({1'b0, cal_temp_q[15:0]});
  assign t2 = $signed(cal_temp_q[31:16]);
  assign t3 = $signed(cal_temp_q[47:32]);
  assign p1 = $signed({1'b0, cal_press_a_q[15:0]});
  assign p2 = $signed(cal_press_a_q[31:16]);
  assign p3 = $signed(cal_press_a_q[47:32]);
  assign p4 = $signed(cal_press_a_q[63:48]);
  assign p5 = $signed(cal_press_b_q[15:0]);
  assign p6 = $signed(cal_press_b_q[31:16]);
  assign p7 = $signed(cal_press_b_q[47:32]);
  assign p8 = $signed(cal_press_b_q[63:48]);
  assign p9 = $signed(cal_mixed_q[15:0]);
  assign h1 = $signed({9'd0, cal_mixed_q[23:16]});
  assign h2 = $signed(cal_mixed_q[39:24]);
  assign h3 = $signed({9'd0, cal_mixed_q[47:40]});
  assign h4 = $signed(cal_hum_q[15:0]);
  assign h5 = $signed(cal_hum_q[31:16]);
  assign h6 = $signed(cal_hum_q[39:32]);

  // ---------------- flow control ----------------
  logic en;
  logic [FrontStages-1:0] fv_q;
  logic [PostStages-1:0]  pv_q;
  logic div_vld;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = out_valid_o && out_stall_i;
  assign out_valid_o = pv_q[PostStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
      pv_q <= '0;
    end else if (en) begin
      fv_q <= {fv_q[FrontStages-2:0], in_valid_i};
      pv_q <= {pv_q[PostStages-2:0], div_vld};
    end
  end

  // ---------------- front stages ----------------
  logic signed [31:0] s1_a_q, s1_d_q;
  logic [RawPW-1:0]   s1_ap_q;
  logic [RawHW-1:0]   s1_ah_q;
  logic signed [31:0] s2_m1_q, s2_dd_q;
  logic signed [31:0] s3_v1_q, s3_e_q;
  logic signed [31:0] s4_tf_q;
  logic signed [31:0] s5_temp_q, s5_hv_q;
  logic signed [33:0] s5_x1_q;
  logic signed [63:0] s6_xsq_q, s6_x5_q, s6_x2p_q;
  logic signed [31:0] s6_ha_q, s6_hbm_q, s6_hcm_q;
  logic signed [63:0] s7_x2a_q, s7_x3a_q, s7_x5s_q, s7_x2s_q;
  logic signed [31:0] s7_hbc_q;
  logic signed [63:0] s8_x2_q, s8_w_q;
  logic signed [31:0] s8_heh2_q;
  logic signed [63:0] s9_wp_q;
  logic signed [31:0] s9_hm_q;
  logic signed [30:0] s10_div_q;
  logic signed [63:0] s10_nb_q;
  logic signed [31:0] s10_hss_q;
  logic signed [63:0] s11_num_q;
  logic signed [30:0] s11_div_q;
  logic signed [31:0] s11_hk_q;
  logic [QuotW-1:0]   s12_an_q;
  logic [DenW-1:0]    s12_ad_q;
  esc_side_t          s12_side_q;
  // carried values
  logic [RawPW-1:0]   ap_c_q [2:9];
  logic [RawHW-1:0]   ah_c_q [2:5];
  logic signed [31:0] temp_c_q [6:11];
  logic signed [31:0] ha_c_q [7:8];
  logic signed [63:0] x2_c_q;
  logic signed [31:0] hm_c_q [10:11];

  logic signed [31:0] ha_pre, hb, hc, he, hf, hs, hv3;
  logic signed [63:0] y_w;
  logic [20:0]        num0;
  logic [HumW-1:0]    hum_w;

  always_comb begin
    ha_pre = $signed({2'd0, ah_c_q[5], 14'd0}) - $signed({h4[11:0], 20'd0})
             - s5_hv_q * h5 + 32'sd16384;
    hb     = s6_hbm_q >>> 10;
    hc     = (s6_hcm_q >>> 11) + 32'sd32768;
    he     = (s7_hbc_q >>> 10) + 32'sd2097152;
    hf     = (s8_heh2_q + 32'sd8192) >>> 14;
    hs     = s9_hm_q >>> 15;
    y_w    = (s7_x3a_q >>> 8) + s7_x2s_q;
    num0   = 21'd1048576 - {1'b0, ap_c_q[9]};
    hv3    = hm_c_q[11] - (s11_hk_q >>> 4);
    if (hv3 < 0) begin
      hum_w = '0;
    end else if (hv3 > 32'sd419430400) begin
      hum_w = HumW'(32'd419430400 >> 12);
    end else begin
      hum_w = hv3[28:12];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // temperature
      s1_a_q  <= $signed({15'd0, raw_temperature_i[19:3]}) - $signed({15'd0, t1[15:0], 1'b0});
      s1_d_q  <= $signed({16'd0, raw_temperature_i[19:4]}) - $signed({16'd0, t1[15:0]});
      s1_ap_q <= raw_pressure_i;
      s1_ah_q <= raw_humidity_i;
      s2_m1_q <= s1_a_q * t2;
      s2_dd_q <= s1_d_q * s1_d_q;
      ap_c_q[2] <= s1_ap_q;
      ah_c_q[2] <= s1_ah_q;
      s3_v1_q <= s2_m1_q >>> 11;
      s3_e_q  <= (s2_dd_q >>> 12) * t3;
      s4_tf_q <= s3_v1_q + (s3_e_q >>> 14);
      s5_temp_q <= (s4_tf_q * 32'sd5 + 32'sd128) >>> 8;
      s5_x1_q   <= s4_tf_q - 34'sd128000;
      s5_hv_q   <= s4_tf_q - 32'sd76800;
      for (int k = 3; k <= 9; k++) ap_c_q[k] <= ap_c_q[k-1];
      for (int k = 3; k <= 5; k++) ah_c_q[k] <= ah_c_q[k-1];
      // stage 6
      s6_xsq_q <= s5_x1_q * s5_x1_q;
      s6_x5_q  <= s5_x1_q * p5;
      s6_x2p_q <= s5_x1_q * p2;
      s6_ha_q  <= ha_pre >>> 15;
      s6_hbm_q <= s5_hv_q * h6;
      s6_hcm_q <= s5_hv_q * h3;
      temp_c_q[6] <= s5_temp_q;
      for (int k = 7; k <= 11; k++) temp_c_q[k] <= temp_c_q[k-1];
      // stage 7
      s7_x2a_q <= s6_xsq_q * p6;
      s7_x3a_q <= s6_xsq_q * p3;
      s7_x5s_q <= s6_x5_q <<< 17;
      s7_x2s_q <= s6_x2p_q <<< 12;
      s7_hbc_q <= hb * hc;
      ha_c_q[7] <= s6_ha_q;
      // stage 8
      s8_x2_q   <= s7_x2a_q + s7_x5s_q + $signed({p4, 35'd0});
      s8_w_q    <= y_w + 64'sd140737488355328;
      s8_heh2_q <= he * h2;
      ha_c_q[8] <= ha_c_q[7];
      // stage 9
      s9_wp_q <= s8_w_q * p1;
      s9_hm_q <= ha_c_q[8] * hf;
      x2_c_q  <= s8_x2_q;
      // stage 10
      s10_div_q  <= s9_wp_q[63:33];
      s10_nb_q   <= $signed({12'd0, num0, 31'd0}) - x2_c_q;
      s10_hss_q  <= hs * hs;
      hm_c_q[10] <= s9_hm_q;
      // stage 11
      s11_num_q  <= s10_nb_q * 64'sd3125;
      s11_div_q  <= s10_div_q;
      s11_hk_q   <= (s10_hss_q >>> 7) * h1;
      hm_c_q[11] <= hm_c_q[10];
      // stage 12
      s12_an_q        <= s11_num_q[63] ? QuotW'(-s11_num_q) : QuotW'(s11_num_q);
      s12_ad_q        <= s11_div_q[30] ? DenW'(-s11_div_q) : DenW'(s11_div_q);
      s12_side_q.neg  <= s11_num_q[63] ^ s11_div_q[30];
      s12_side_q.zero <= s11_div_q == '0;
      s12_side_q.temp <= temp_c_q[11];
      s12_side_q.hum  <= hum_w;
    end
  end

  // ---------------- divider ----------------
  logic [QuotW-1:0] div_quot;
  esc_side_t        div_side;

  esc_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv_q[FrontStages-1]),
    .num_i   (s12_an_q),
    .den_i   (s12_ad_q),
    .side_i  (s12_side_q),
    .valid_o (div_vld),
    .quot_o  (div_quot),
    .side_o  (div_side)
  );

  // ---------------- back stages ----------------
  logic signed [63:0] b1_p_q;
  logic signed [63:0] b2_p_q, b2_t_q, b2_ps_q, b2_y2m_q;
  logic [63:0]        b3_pp0_q;
  logic [31:0]        b3_pp1_q, b3_pp2_q;
  logic signed [63:0] b3_p_q, b3_y2_q;
  logic signed [63:0] b4_sum_q;
  esc_side_t          side_c_q [1:4];
  logic [63:0]        y1m;
  logic signed [63:0] ps_w, y1, res_w;

  always_comb begin
    ps_w  = b1_p_q >>> 13;
    y1m   = b3_pp0_q + {b3_pp1_q + b3_pp2_q, 32'd0};
    y1    = $signed(y1m) >>> 25;
    res_w = (b4_sum_q >>> 8) + $signed({p7, 4'd0});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_p_q      <= div_side.neg ? $signed(-div_quot) : $signed(div_quot);
      side_c_q[1] <= div_side;
      b2_p_q      <= b1_p_q;
      b2_ps_q     <= ps_w;
      b2_t_q      <= ps_w * p9;
      b2_y2m_q    <= b1_p_q * p8;
      for (int k = 2; k <= 4; k++) side_c_q[k] <= side_c_q[k-1];
      b3_pp0_q    <= b2_t_q[31:0] * b2_ps_q[31:0];
      b3_pp1_q    <= b2_t_q[31:0] * b2_ps_q[63:32];
      b3_pp2_q    <= b2_t_q[63:32] * b2_ps_q[31:0];
      b3_p_q      <= b2_p_q;
      b3_y2_q     <= b2_y2m_q >>> 19;
      b4_sum_q    <= b3_p_q + y1 + b3_y2_q;
      temperature_o <= side_c_q[4].temp;
      humidity_o    <= side_c_q[4].hum;
      pressure_o    <= side_c_q[4].zero ? '0 : res_w[31:0];
    end
  end

endmodule

[tb/tb_env_sensor_compensation.sv]
// Testbench for env_sensor_compensation: directed table then random samples,
// checked against an in-bench fixed-point compensation predictor. Depends on esc_pkg.
module tb_env_sensor_compensation import esc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 20000;
  localparam int Latency    = 81;

  typedef struct packed {
    logic [TempW-1:0]  temp;
    logic [PressW-1:0] press;
    logic [HumW-1:0]   hum;
  } comp_t;

  typedef struct {
    logic [RawTW-1:0] rt;
    logic [RawPW-1:0] rp;
    logic [RawHW-1:0] rh;
    bit               known;
    comp_t            want;
  } row_t;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_stall_i = 0;
  logic [RawTW-1:0] raw_temperature_i = '0;
  logic [RawPW-1:0] raw_pressure_i = '0;
  logic [RawHW-1:0] raw_humidity_i = '0;
  logic in_stall_o, out_valid_o, pready;
  logic [TempW-1:0] temperature_o;
  logic [PressW-1:0] pressure_o;
  logic [HumW-1:0] humidity_o;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0, prdata;

  env_sensor_compensation uut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  logic [47:0] c_temp, c_mixed;
  logic [63:0] c_pa, c_pb;
  logic [39:0] c_hum;
  comp_t pending[$];
  bit failed = 0;
  int idle_in = 0, idle_out = 0, quiet = 0;

  function automatic logic [31:0] asr32(logic [31:0] x, int s);
    return $signed(x) >>> s;
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int s);
    return $signed(x) >>> s;
  endfunction

  function automatic comp_t compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    logic [31:0] t1, t2, t3, a, v1, d, v2, tf, tmp, v, ha, hb, hc, he, hf, h1, h2, h3, h4, h5, h6;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, x1, x2, p, y1, y2, num, an, ad, q;
    comp_t r;
    t1 = {16'd0, c_temp[15:0]};
    t2 = {{16{c_temp[31]}}, c_temp[31:16]};
    t3 = {{16{c_temp[47]}}, c_temp[47:32]};
    p1 = {48'd0, c_pa[15:0]};
    p2 = {{48{c_pa[31]}}, c_pa[31:16]};
    p3 = {{48{c_pa[47]}}, c_pa[47:32]};
    p4 = {{48{c_pa[63]}}, c_pa[63:48]};
    p5 = {{48{c_pb[15]}}, c_pb[15:0]};
    p6 = {{48{c_pb[31]}}, c_pb[31:16]};
    p7 = {{48{c_pb[47]}}, c_pb[47:32]};
    p8 = {{48{c_pb[63]}}, c_pb[63:48]};
    p9 = {{48{c_mixed[15]}}, c_mixed[15:0]};
    h1 = {24'd0, c_mixed[23:16]};
    h2 = {{16{c_mixed[39]}}, c_mixed[39:24]};
    h3 = {24'd0, c_mixed[47:40]};
    h4 = {{16{c_hum[15]}}, c_hum[15:0]};
    h5 = {{16{c_hum[31]}}, c_hum[31:16]};
    h6 = {{24{c_hum[39]}}, c_hum[39:32]};
    a = {12'd0, rt} >> 3;
    a = a - (t1 << 1);
    v1 = asr32(a * t2, 11);
    d = ({12'd0, rt} >> 4) - t1;
    v2 = asr32(asr32(d * d, 12) * t3, 14);
    tf = v1 + v2;
    tmp = asr32(tf * 32'd5 + 32'd128, 8);
    r.temp = tmp;
    x1 = {{32{tf[31]}}, tf} - 64'd128000;
    x2 = x1 * x1 * p6;
    x2 = x2 + ((x1 * p5) << 17);
    x2 = x2 + (p4 << 35);
    x1 = asr64(x1 * x1 * p3, 8) + ((x1 * p2) << 12);
    x1 = asr64(((64'd1 << 47) + x1) * p1, 33);
    r.press = '0;
    if (x1 != 0) begin
      p = 64'd1048576 - {44'd0, rp};
      num = ((p << 31) - x2) * 64'd3125;
      an = num[63] ? -num : num;
      ad = x1[63] ? -x1 : x1;
      q = an / ad;
      p = (num[63] != x1[63]) ? -q : q;
      y1 = asr64(p9 * asr64(p, 13) * asr64(p, 13), 25);
      y2 = asr64(p8 * p, 19);
      p = asr64(p + y1 + y2, 8) + (p7 << 4);
      r.press = p[31:0];
    end
    v = tf - 32'd76800;
    ha = asr32(({16'd0, rh} << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
    hb = asr32(v * h6, 10);
    hc = asr32(v * h3, 11) + 32'd32768;
    he = asr32(hb * hc, 10) + 32'd2097152;
    hf = asr32(he * h2 + 32'd8192, 14);
    v = ha * hf;
    v = v - asr32(asr32(asr32(v, 15) * asr32(v, 15), 7) * h1, 4);
    if (v[31]) v = 0;
    if (v > 32'd419430400) v = 32'd419430400;
    r.hum = v[28:12];
    return r;
  endfunction

  task automatic reg_write(esc_reg_e idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= AddrW'(8 * int'(idx)); pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      RegCalTemp:   c_temp = val[47:0];
      RegCalPressA: c_pa = val;
      RegCalPressB: c_pb = val;
      RegCalMixed:  c_mixed = val[47:0];
      RegCalHum:    c_hum = val[39:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic send(row_t r);
    @(negedge clk_i);
    while (idle_in > 0 && $urandom_range(99) < idle_in) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    raw_temperature_i <= r.rt; raw_pressure_i <= r.rp; raw_humidity_i <= r.rh;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending.push_back(r.known ? r.want : compensate(r.rt, r.rp, r.rh));
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  always @(negedge clk_i)
    out_stall_i <= (idle_out > 0) && ($urandom_range(99) < idle_out);

  always @(posedge clk_i) begin
    comp_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h %h %h", $time, temperature_o, pressure_o,
                 humidity_o);
        failed = 1;
      end else begin
        w = pending.pop_front();
        if (w.temp !== temperature_o) begin
          $display("%0t temperature exp %h got %h", $time, w.temp, temperature_o);
          failed = 1;
        end
        if (w.press !== pressure_o) begin
          $display("%0t pressure exp %h got %h", $time, w.press, pressure_o);
          failed = 1;
        end
        if (w.hum !== humidity_o) begin
          $display("%0t humidity exp %h got %h", $time, w.hum, humidity_o);
          failed = 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // typical calibration near a real sensor part
  task automatic cal_typical();
    reg_write(RegCalTemp, 64'({16'd50, 16'd26435, 16'd27504}));
    reg_write(RegCalPressA, {16'd2855, 16'd3024, -16'sd10685, 16'd36477});
    reg_write(RegCalPressB, {-16'sd10230, 16'd15500, -16'sd7, 16'd140});
    reg_write(RegCalMixed, 64'({8'd0, 16'd360, 8'd75, 16'd6000}));
    reg_write(RegCalHum, 64'({8'd30, 16'd50, 16'd339}));
  endtask

  initial begin
    row_t tbl[$];
    row_t r;
    comp_t z;
    c_temp = 0; c_pa = 0; c_pb = 0; c_mixed = 0; c_hum = 0;
    repeat (2) @(posedge clk_i);
    #1 rst_ni = 1;
    // all calibration zero: divisor zero gives pressure 0, temp and humidity 0
    z = '0;
    tbl.push_back('{20'd0, 20'd0, 16'd0, 1, z});
    tbl.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1, z});
    foreach (tbl[i]) send(tbl[i]);
    release_input();
    drain();
    cal_typical();
    tbl.delete();
    tbl.push_back('{20'd0, 20'd0, 16'd0, 0, z});
    tbl.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0, z});
    tbl.push_back('{20'd519888, 20'd415148, 16'd30000, 0, z});
    tbl.push_back('{20'hFFFFF, 20'd0, 16'd0, 0, z});
    tbl.push_back('{20'd0, 20'hFFFFF, 16'hFFFF, 0, z});
    tbl.push_back('{20'h55555, 20'hAAAAA, 16'h5555, 0, z});
    tbl.push_back('{20'hAAAAA, 20'h55555, 16'hAAAA, 0, z});
    foreach (tbl[i]) send(tbl[i]);
    release_input();
    drain();
    // extreme calibration words
    reg_write(RegCalTemp, '1);
    reg_write(RegCalPressA, '1);
    reg_write(RegCalPressB, '1);
    reg_write(RegCalMixed, '1);
    reg_write(RegCalHum, '1);
    foreach (tbl[i]) send(tbl[i]);
    release_input();
    drain();
    reg_write(RegCalTemp, 64'h8000_8000_0000);
    reg_write(RegCalPressA, 64'h8000_8000_8000_FFFF);
    reg_write(RegCalPressB, 64'h8000_8000_8000_8000);
    reg_write(RegCalMixed, 64'hFF_8000_FF_8000);
    reg_write(RegCalHum, 64'h80_8000_8000);
    foreach (tbl[i]) send(tbl[i]);
    release_input();
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_in = 0;  idle_out = 0;  end
        1: begin idle_in = 71; idle_out = 0;  end
        2: begin idle_in = 0;  idle_out = 71; end
        default: begin idle_in = 30; idle_out = 30; end
      endcase
      if (ph < 4) cal_typical();
      else begin
        reg_write(RegCalTemp, rnd64());
        reg_write(RegCalPressA, rnd64());
        reg_write(RegCalPressB, rnd64());
        reg_write(RegCalMixed, rnd64());
        reg_write(RegCalHum, rnd64());
      end
      for (int k = 0; k < 85; k++) begin
        r.known = 0; r.want = z;
        if (ph < 4 && $urandom_range(3) != 0) begin
          r.rt = RawTW'($urandom_range(600000, 400000));
          r.rp = RawPW'($urandom_range(500000, 250000));
        end else begin
          r.rt = RawTW'($urandom); r.rp = RawPW'($urandom);
        end
        r.rh = RawHW'($urandom);
        send(r);
        if ($urandom_range(9) == 0) release_input();
      end
      release_input();
      idle_out = 0;
      drain();
    end
    idle_in = 0;
    if (!failed && pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
